/* design/xmr_pkg.sv */
// XMODEM receiver package: phase and opcode types, protocol characters
// and the CRC-16 byte update. No dependencies.
package xmr_pkg;

   typedef enum logic [2:0] {
      PH_IDLE   = 3'd0,
      PH_HEADER = 3'd1,
      PH_BLKNUM = 3'd2,
      PH_DATA   = 3'd3,
      PH_CHECK  = 3'd4
   } phase_type;

   typedef enum logic [1:0] {
      OP_START = 2'd0,
      OP_BYTE  = 2'd1,
      OP_ABORT = 2'd2
   } opcode_type;

   typedef enum logic [1:0] {
      ST_RUN   = 2'd0,
      ST_EOT   = 2'd1,
      ST_ABORT = 2'd2
   } status_type;

   localparam logic [7:0]  CH_SOH   = 8'h01;
   localparam logic [7:0]  CH_EOT   = 8'h04;
   localparam logic [7:0]  CH_ACK   = 8'h06;
   localparam logic [7:0]  CH_NAK   = 8'h15;
   localparam logic [7:0]  CH_C     = 8'h43;
   localparam logic [15:0] CRC_POLY = 16'h1021;

   // CCITT CRC-16, MSB first, one byte
   function automatic logic [15:0] crc_update(input logic [15:0] crc,
                                              input logic [7:0]  data);
      logic [15:0] c;
      c = crc ^ {data, 8'h00};
      for (int k = 0; k < 8; k++) begin
         if (c[15]) begin
            c = {c[14:0], 1'b0} ^ CRC_POLY;
         end else begin
            c = {c[14:0], 1'b0};
         end
      end
      return c;
   endfunction

endpackage

/* design/xmodem_packet_receiver_top.sv */
// XMODEM packet receiver: one received event per word, one result word each.
// Depends on xmr_pkg (types, characters, CRC update).
//
// Usage:
//   req_ channel carries one event per word: opcode (start, byte, abort) and
//   the received serial byte. rsp_ channel returns exactly one word per event:
//   reply byte to transmit, tentative payload byte, packet done/good flags and
//   transfer status. csr_ channel writes crc_mode (1 = CRC-16, 0 = checksum);
//   csr_ready is always high, write it only while the block is idle.
// Timing:
//   An accepted event is held in an input register, then all protocol work
//   (phase update, CRC or sum of one byte, check compare) runs combinationally
//   into the result register. rsp_valid rises when the word moves from the
//   input register into the result register. The byte CRC is combinational.
//   Throughput is one word per cycle while no result is held by rsp_stall.
// Reset:
//   Synchronous, active high. Phase goes idle, counters and checks clear,
//   crc_mode returns to CRC-16, both pipeline registers empty.
// Stall:
//   While rsp_stall holds a result, the input register fills and then
//   req_stall rises; no word is lost or repeated.
module xmodem_packet_receiver_top #(
   parameter int PACKET_BYTES = 128
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [1:0] req_opcode,
   input  logic [7:0] req_rx_byte,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic       rsp_send_valid,
   output logic [7:0] rsp_send_byte,
   output logic       rsp_data_valid,
   output logic [7:0] rsp_data_byte,
   output logic       rsp_packet_done,
   output logic       rsp_packet_good,
   output logic [1:0] rsp_transfer_status,
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic       csr_data
);

   localparam int CNT_W = $clog2(PACKET_BYTES);
   localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(PACKET_BYTES - 1);

   logic                crc_mode_ff;
   logic                in_valid_ff;
   logic [1:0]          in_opcode_ff;
   logic [7:0]          in_byte_ff;
   logic                advance;

   xmr_pkg::phase_type  phase_ff, phase_in;
   logic                hdr_idx_ff, hdr_idx_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic [15:0]         calc_ff, calc_in;
   logic [7:0]          rcv_hi_ff, rcv_hi_in;

   logic                rsp_valid_ff;
   logic                send_valid_ff, send_valid_in;
   logic [7:0]          send_byte_ff, send_byte_in;
   logic                data_valid_ff, data_valid_in;
   logic [7:0]          data_byte_ff, data_byte_in;
   logic                done_ff, done_in;
   logic                good_ff, good_in;
   xmr_pkg::status_type status_ff, status_in;
   logic                match;

   assign csr_ready = 1'b1;
   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign req_stall = in_valid_ff && !advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         crc_mode_ff <= 1'b1;
      end else if (csr_valid && csr_ready) begin
         crc_mode_ff <= csr_data;
      end
   end

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (!req_stall && req_valid) begin
         in_opcode_ff <= req_opcode;
         in_byte_ff   <= req_rx_byte;
      end
   end

   always_comb begin
      if (crc_mode_ff) begin
         match = ({rcv_hi_ff, in_byte_ff} == calc_ff);
      end else begin
         match = (in_byte_ff == calc_ff[7:0]);
      end
   end

   always_comb begin
      phase_in      = phase_ff;
      hdr_idx_in    = hdr_idx_ff;
      count_in      = count_ff;
      calc_in       = calc_ff;
      rcv_hi_in     = rcv_hi_ff;
      send_valid_in = 1'b0;
      send_byte_in  = 8'h00;
      data_valid_in = 1'b0;
      data_byte_in  = 8'h00;
      done_in       = 1'b0;
      good_in       = 1'b0;
      status_in     = xmr_pkg::ST_RUN;
      case (xmr_pkg::opcode_type'(in_opcode_ff))
         xmr_pkg::OP_START: begin
            send_valid_in = 1'b1;
            send_byte_in  = crc_mode_ff ? xmr_pkg::CH_C : xmr_pkg::CH_NAK;
            phase_in      = xmr_pkg::PH_HEADER;
            hdr_idx_in    = 1'b0;
            count_in      = '0;
            calc_in       = '0;
            rcv_hi_in     = '0;
         end
         xmr_pkg::OP_ABORT: begin
            phase_in   = xmr_pkg::PH_IDLE;
            hdr_idx_in = 1'b0;
            status_in  = xmr_pkg::ST_ABORT;
         end
         xmr_pkg::OP_BYTE: begin
            case (phase_ff)
               xmr_pkg::PH_HEADER: begin
                  if (in_byte_ff == xmr_pkg::CH_SOH) begin
                     phase_in   = xmr_pkg::PH_BLKNUM;
                     hdr_idx_in = 1'b0;
                  end else if (in_byte_ff == xmr_pkg::CH_EOT) begin
                     send_valid_in = 1'b1;
                     send_byte_in  = xmr_pkg::CH_ACK;
                     status_in     = xmr_pkg::ST_EOT;
                     phase_in      = xmr_pkg::PH_IDLE;
                  end
               end
               xmr_pkg::PH_BLKNUM: begin
                  // skip block number and its complement
                  if (!hdr_idx_ff) begin
                     hdr_idx_in = 1'b1;
                  end else begin
                     hdr_idx_in = 1'b0;
                     count_in   = '0;
                     calc_in    = '0;
                     rcv_hi_in  = '0;
                     phase_in   = xmr_pkg::PH_DATA;
                  end
               end
               xmr_pkg::PH_DATA: begin
                  data_valid_in = 1'b1;
                  data_byte_in  = in_byte_ff;
                  if (crc_mode_ff) begin
                     calc_in = xmr_pkg::crc_update(calc_ff, in_byte_ff);
                  end else begin
                     calc_in = calc_ff + {8'h00, in_byte_ff};
                  end
                  if (count_ff == LAST_CNT) begin
                     count_in   = '0;
                     hdr_idx_in = 1'b0;
                     phase_in   = xmr_pkg::PH_CHECK;
                  end else begin
                     count_in = count_ff + 1'b1;
                  end
               end
               xmr_pkg::PH_CHECK: begin
                  if (crc_mode_ff && !hdr_idx_ff) begin
                     rcv_hi_in  = in_byte_ff;
                     hdr_idx_in = 1'b1;
                  end else begin
                     done_in       = 1'b1;
                     good_in       = match;
                     send_valid_in = 1'b1;
                     send_byte_in  = match ? xmr_pkg::CH_ACK : xmr_pkg::CH_NAK;
                     hdr_idx_in    = 1'b0;
                     phase_in      = xmr_pkg::PH_HEADER;
                  end
               end
               default: begin
               end
            endcase
         end
         default: begin
         end
      endcase
   end

   // protocol state advances as the word moves into the result register
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= xmr_pkg::PH_IDLE;
         hdr_idx_ff <= 1'b0;
         count_ff   <= '0;
         calc_ff    <= '0;
         rcv_hi_ff  <= '0;
      end else if (in_valid_ff && advance) begin
         phase_ff   <= phase_in;
         hdr_idx_ff <= hdr_idx_in;
         count_ff   <= count_in;
         calc_ff    <= calc_in;
         rcv_hi_ff  <= rcv_hi_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid_ff && advance) begin
         send_valid_ff <= send_valid_in;
         send_byte_ff  <= send_byte_in;
         data_valid_ff <= data_valid_in;
         data_byte_ff  <= data_byte_in;
         done_ff       <= done_in;
         good_ff       <= good_in;
         status_ff     <= status_in;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_send_valid      = send_valid_ff;
   assign rsp_send_byte       = send_byte_ff;
   assign rsp_data_valid      = data_valid_ff;
   assign rsp_data_byte       = data_byte_ff;
   assign rsp_packet_done     = done_ff;
   assign rsp_packet_good     = good_ff;
   assign rsp_transfer_status = status_ff;

`ifndef SYNTHESIS
   a_done_replies: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && done_ff |-> send_valid_ff)
      else $error("packet end without reply byte");

   a_good_in_packet: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && good_ff |-> done_ff)
      else $error("packet_good outside packet end");

   a_data_alone: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && data_valid_ff |-> !send_valid_ff && status_ff == xmr_pkg::ST_RUN)
      else $error("payload word carries reply or status");

   a_abort_idles: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && advance && in_opcode_ff == xmr_pkg::OP_ABORT
      |=> phase_ff == xmr_pkg::PH_IDLE)
      else $error("abort did not return to idle");

   a_stall_holds_state: assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(phase_ff) && $stable(calc_ff))
      else $error("state moved while result stalled");
`endif

endmodule

/* test/xmodem_packet_receiver_checker.sv */
// Result checker for the XMODEM packet receiver: watches the req_, rsp_ and csr_
// channels, predicts every reply word and compares it field by field.
// Depends on xmr_pkg for phases, opcodes, status codes and protocol characters.
module xmodem_packet_receiver_checker #(
   parameter int PACKET_BYTES = 128
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       req_stall,
   input  logic [1:0] req_opcode,
   input  logic [7:0] req_rx_byte,
   input  logic       rsp_valid,
   input  logic       rsp_stall,
   input  logic       rsp_send_valid,
   input  logic [7:0] rsp_send_byte,
   input  logic       rsp_data_valid,
   input  logic [7:0] rsp_data_byte,
   input  logic       rsp_packet_done,
   input  logic       rsp_packet_good,
   input  logic [1:0] rsp_transfer_status,
   input  logic       csr_valid,
   input  logic       csr_ready,
   input  logic       csr_data,
   output int         fail_count,
   output int         pending,
   output int         checked
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic       send_valid;
      logic [7:0] send_byte;
      logic       data_valid;
      logic [7:0] data_byte;
      logic       packet_done;
      logic       packet_good;
      logic [1:0] status;
   } reply_word_type;

   reply_word_type reply_q[$];
   int             errors;
   int             n_checked;

   // receiver state as the predictor sees it
   logic               crc_sel;
   xmr_pkg::phase_type rx_phase;
   logic               check_half;
   int                 payload_seen;
   logic [15:0]        running_check;
   logic [15:0]        taken_check;

   // CCITT CRC-16 over one byte, fed one data bit at a time
   function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] d);
      logic [15:0] c;
      logic        fb;
      c = crc;
      for (int i = 7; i >= 0; i--) begin
         fb = c[15] ^ d[i];
         c  = {c[14:0], 1'b0} ^ (fb ? 16'h1021 : 16'h0000);
      end
      return c;
   endfunction

   task automatic predict_reply(input logic [1:0] op, input logic [7:0] b,
                                output reply_word_type r);
      logic good;
      r = '0;
      case (op)
         xmr_pkg::OP_START: begin
            r.send_valid  = 1'b1;
            r.send_byte   = crc_sel ? xmr_pkg::CH_C : xmr_pkg::CH_NAK;
            rx_phase      = xmr_pkg::PH_HEADER;
            check_half    = 1'b0;
            payload_seen  = 0;
            running_check = '0;
            taken_check   = '0;
         end
         xmr_pkg::OP_ABORT: begin
            rx_phase   = xmr_pkg::PH_IDLE;
            check_half = 1'b0;
            r.status   = xmr_pkg::ST_ABORT;
         end
         xmr_pkg::OP_BYTE: begin
            case (rx_phase)
               xmr_pkg::PH_HEADER: begin
                  if (b == xmr_pkg::CH_SOH) begin
                     rx_phase   = xmr_pkg::PH_BLKNUM;
                     check_half = 1'b0;
                  end else if (b == xmr_pkg::CH_EOT) begin
                     r.send_valid = 1'b1;
                     r.send_byte  = xmr_pkg::CH_ACK;
                     r.status     = xmr_pkg::ST_EOT;
                     rx_phase     = xmr_pkg::PH_IDLE;
                  end
               end
               xmr_pkg::PH_BLKNUM: begin
                  if (!check_half) begin
                     check_half = 1'b1;
                  end else begin
                     check_half    = 1'b0;
                     payload_seen  = 0;
                     running_check = '0;
                     taken_check   = '0;
                     rx_phase      = xmr_pkg::PH_DATA;
                  end
               end
               xmr_pkg::PH_DATA: begin
                  r.data_valid  = 1'b1;
                  r.data_byte   = b;
                  running_check = crc_sel ? crc16_byte(running_check, b)
                                          : running_check + {8'h00, b};
                  payload_seen++;
                  if (payload_seen >= PACKET_BYTES) begin
                     payload_seen = 0;
                     check_half   = 1'b0;
                     rx_phase     = xmr_pkg::PH_CHECK;
                  end
               end
               xmr_pkg::PH_CHECK: begin
                  if (crc_sel && !check_half) begin
                     taken_check = {b, 8'h00};
                     check_half  = 1'b1;
                  end else begin
                     if (crc_sel) begin
                        taken_check = {taken_check[15:8], b};
                        good        = (taken_check == running_check);
                     end else begin
                        taken_check = {8'h00, b};
                        good        = (b == running_check[7:0]);
                     end
                     r.packet_done = 1'b1;
                     r.packet_good = good;
                     r.send_valid  = 1'b1;
                     r.send_byte   = good ? xmr_pkg::CH_ACK : xmr_pkg::CH_NAK;
                     check_half    = 1'b0;
                     rx_phase      = xmr_pkg::PH_HEADER;
                  end
               end
               default: ;
            endcase
         end
         default: ;
      endcase
   endtask

   task automatic check_field(input string name, input logic [7:0] exp, input logic [7:0] act);
      if (exp !== act) begin
         $error("%s: expected %0h, got %0h", name, exp, act);
         errors++;
      end
   endtask

   always @(posedge clock) begin
      reply_word_type r;
      if (reset) begin
         reply_q.delete();
         crc_sel       = 1'b1;
         rx_phase      = xmr_pkg::PH_IDLE;
         check_half    = 1'b0;
         payload_seen  = 0;
         running_check = '0;
         taken_check   = '0;
      end else begin
         if (csr_valid && csr_ready) begin
            crc_sel = csr_data;
         end
         if (rsp_valid && !rsp_stall) begin
            if (reply_q.size() == 0) begin
               $error("reply word with nothing outstanding");
               errors++;
            end else begin
               r = reply_q.pop_front();
               n_checked++;
               check_field("send_valid", 8'(r.send_valid), 8'(rsp_send_valid));
               check_field("send_byte", r.send_byte, rsp_send_byte);
               check_field("data_valid", 8'(r.data_valid), 8'(rsp_data_valid));
               check_field("data_byte", r.data_byte, rsp_data_byte);
               check_field("packet_done", 8'(r.packet_done), 8'(rsp_packet_done));
               check_field("packet_good", 8'(r.packet_good), 8'(rsp_packet_good));
               check_field("transfer_status", 8'(r.status), 8'(rsp_transfer_status));
            end
         end
         if (req_valid && !req_stall) begin
            predict_reply(req_opcode, req_rx_byte, r);
            reply_q.push_back(r);
         end
      end
      fail_count <= errors;
      pending    <= reply_q.size();
      checked    <= n_checked;
   end

endmodule

/* test/tb_xmodem_packet_receiver_top.sv */
// Testbench top for the XMODEM packet receiver: clock, reset, event and csr
// stimulus, random idling on both channels, and the final verdict.
// Depends on xmr_pkg, xmodem_packet_receiver_top and xmodem_packet_receiver_checker.
module tb_xmodem_packet_receiver_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int         PACKET_BYTES = 128;
   localparam int         EVENT_TARGET = 1750;
   localparam logic [1:0] OP_RESERVED  = 2'd3;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic [1:0] req_opcode = '0;
   logic [7:0] req_rx_byte = '0;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic       rsp_send_valid;
   logic [7:0] rsp_send_byte;
   logic       rsp_data_valid;
   logic [7:0] rsp_data_byte;
   logic       rsp_packet_done;
   logic       rsp_packet_good;
   logic [1:0] rsp_transfer_status;
   logic       csr_valid = 1'b0;
   logic       csr_ready;
   logic       csr_data = 1'b0;

   int fail_count;
   int pending;
   int checked;

   // stimulus bookkeeping
   bit cur_mode = 1'b1;
   bit in_transfer = 1'b0;
   bit req_gaps_on = 1'b0;
   bit rsp_stalls_on = 1'b0;
   int events_sent = 0;
   int packets = 0;
   int bad_packets = 0;
   int eots = 0;
   int aborts = 0;
   int stall_left = 0;

   always #5 clock = ~clock;

   xmodem_packet_receiver_top #(.PACKET_BYTES(PACKET_BYTES)) u_top (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_opcode          (req_opcode),
      .req_rx_byte         (req_rx_byte),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_send_valid      (rsp_send_valid),
      .rsp_send_byte       (rsp_send_byte),
      .rsp_data_valid      (rsp_data_valid),
      .rsp_data_byte       (rsp_data_byte),
      .rsp_packet_done     (rsp_packet_done),
      .rsp_packet_good     (rsp_packet_good),
      .rsp_transfer_status (rsp_transfer_status),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_data            (csr_data)
   );

   xmodem_packet_receiver_checker #(.PACKET_BYTES(PACKET_BYTES)) u_check (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_opcode          (req_opcode),
      .req_rx_byte         (req_rx_byte),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_send_valid      (rsp_send_valid),
      .rsp_send_byte       (rsp_send_byte),
      .rsp_data_valid      (rsp_data_valid),
      .rsp_data_byte       (rsp_data_byte),
      .rsp_packet_done     (rsp_packet_done),
      .rsp_packet_good     (rsp_packet_good),
      .rsp_transfer_status (rsp_transfer_status),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_data            (csr_data),
      .fail_count          (fail_count),
      .pending             (pending),
      .checked             (checked)
   );

   // receiver back-pressure: rsp_stall raised in random bursts
   always @(posedge clock) begin
      if (reset || !rsp_stalls_on) begin
         rsp_stall  <= 1'b0;
         stall_left = 0;
      end else if (stall_left > 0) begin
         rsp_stall <= 1'b1;
         stall_left--;
      end else if ($urandom_range(0, 4) == 0) begin
         rsp_stall  <= 1'b1;
         stall_left = $urandom_range(0, 2);
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // present one event word and hold it until taken
   task automatic put_word(input logic [1:0] op, input logic [7:0] b);
      if (req_gaps_on && $urandom_range(0, 4) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_opcode  <= op;
      req_rx_byte <= b;
      do @(posedge clock); while (req_stall);
      if (op != OP_RESERVED) events_sent++;
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending != 0);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_mode(input bit m);
      drain();
      csr_valid <= 1'b1;
      csr_data  <= m;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      cur_mode = m;
   endtask

   // fill: 0 random payload, 1 all zeros, 2 all ones
   task automatic send_packet(input bit corrupt, input int fill);
      logic [7:0]  words[$];
      logic [15:0] chk;
      logic [7:0]  d;
      int          brk;
      int          idx;
      int          act;
      chk = '0;
      if (!in_transfer || $urandom_range(0, 3) == 0) begin
         put_word(xmr_pkg::OP_START, 8'($urandom_range(0, 255)));
      end
      in_transfer = 1'b1;
      // junk in the header phase is dropped by the receiver
      if ($urandom_range(0, 4) == 0) begin
         do d = 8'($urandom_range(0, 255));
         while (d == xmr_pkg::CH_SOH || d == xmr_pkg::CH_EOT);
         put_word(xmr_pkg::OP_BYTE, d);
      end
      d = 8'($urandom_range(0, 255));
      words.push_back(xmr_pkg::CH_SOH);
      words.push_back(d);
      words.push_back(~d);
      for (int i = 0; i < PACKET_BYTES; i++) begin
         d = (fill == 1) ? 8'h00 : (fill == 2) ? 8'hFF : 8'($urandom_range(0, 255));
         words.push_back(d);
         chk = cur_mode ? u_check.crc16_byte(chk, d) : chk + {8'h00, d};
      end
      if (cur_mode) begin
         words.push_back(chk[15:8]);
      end
      words.push_back(chk[7:0]);
      if (corrupt) begin
         idx = words.size() - 1 - (cur_mode ? $urandom_range(0, 1) : 0);
         words[idx] = words[idx] ^ (8'h01 << $urandom_range(0, 7));
      end
      brk = ($urandom_range(0, 9) == 0) ? $urandom_range(0, words.size() - 1) : -1;
      for (int i = 0; i < words.size(); i++) begin
         if (i == brk) begin
            act = $urandom_range(0, 2);
            if (act == 0) begin
               put_word(xmr_pkg::OP_ABORT, 8'($urandom_range(0, 255)));
               in_transfer = 1'b0;
               aborts++;
               return;
            end else if (act == 1) begin
               put_word(xmr_pkg::OP_START, 8'($urandom_range(0, 255)));
               return;
            end
            put_word(OP_RESERVED, 8'($urandom_range(0, 255)));
         end
         put_word(xmr_pkg::OP_BYTE, words[i]);
      end
      packets++;
      if (corrupt) bad_packets++;
   endtask

   initial begin
      #3ms;
      $display("FAILED: results differ");
      $finish;
   end

   initial begin
      int scen;
      int sel;
      scen = 0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // directed: idle handling, ignored words, EOT, restarts, both start replies
      put_word(OP_RESERVED, 8'hFF);
      put_word(xmr_pkg::OP_BYTE, 8'hFF);
      put_word(xmr_pkg::OP_ABORT, 8'h00);
      put_word(xmr_pkg::OP_START, 8'h00);
      put_word(xmr_pkg::OP_BYTE, 8'h00);
      put_word(xmr_pkg::OP_BYTE, 8'hFF);
      put_word(xmr_pkg::OP_BYTE, xmr_pkg::CH_EOT);
      put_word(xmr_pkg::OP_BYTE, xmr_pkg::CH_SOH);
      put_word(xmr_pkg::OP_START, 8'hFF);
      put_word(xmr_pkg::OP_BYTE, xmr_pkg::CH_SOH);
      put_word(xmr_pkg::OP_BYTE, 8'h00);
      put_word(xmr_pkg::OP_ABORT, 8'hFF);
      put_word(xmr_pkg::OP_START, 8'h00);
      put_word(xmr_pkg::OP_BYTE, xmr_pkg::CH_SOH);
      put_word(xmr_pkg::OP_BYTE, 8'hFF);
      put_word(xmr_pkg::OP_BYTE, 8'h00);
      put_word(xmr_pkg::OP_BYTE, 8'hA5);
      put_word(OP_RESERVED, 8'h5A);
      put_word(xmr_pkg::OP_START, 8'h00);
      put_word(xmr_pkg::OP_BYTE, xmr_pkg::CH_EOT);
      write_mode(1'b0);
      put_word(xmr_pkg::OP_START, 8'h00);
      put_word(xmr_pkg::OP_BYTE, xmr_pkg::CH_EOT);
      put_word(xmr_pkg::OP_ABORT, 8'h00);
      in_transfer = 1'b0;

      while (events_sent < EVENT_TARGET) begin
         if (events_sent > EVENT_TARGET - 300) begin
            req_gaps_on   = 1'b0;
            rsp_stalls_on = 1'b0;
         end else begin
            req_gaps_on   = ($urandom_range(0, 9) < 7);
            rsp_stalls_on = ($urandom_range(0, 9) < 7);
         end
         // alternate the check mode, with an occasional extra rewrite
         if (scen % 4 == 0) begin
            write_mode(scen[2]);
         end else if ($urandom_range(0, 7) == 0) begin
            write_mode(1'($urandom_range(0, 1)));
         end
         sel = $urandom_range(0, 99);
         if (sel < 70) begin
            send_packet($urandom_range(0, 3) == 0,
                        (packets < 2) ? packets + 1 : ($urandom_range(0, 9) == 0 ? 2 : 0));
         end else if (sel < 80) begin
            if (!in_transfer) put_word(xmr_pkg::OP_START, 8'($urandom_range(0, 255)));
            put_word(xmr_pkg::OP_BYTE, xmr_pkg::CH_EOT);
            in_transfer = 1'b0;
            eots++;
         end else if (sel < 88) begin
            put_word(xmr_pkg::OP_ABORT, 8'($urandom_range(0, 255)));
            in_transfer = 1'b0;
            aborts++;
         end else begin
            repeat ($urandom_range(1, 4)) begin
               put_word(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
            end
            in_transfer = 1'b0;
         end
         scen++;
      end

      drain();
      $display("Sent %0d events over both check modes: %0d packets (%0d with bad check),",
               events_sent, packets, bad_packets);
      $display("%0d end-of-transfer words, %0d aborts; %0d reply words compared.",
               eots, aborts, checked);
      if (fail_count == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule

/* sim.f */
design/xmr_pkg.sv
design/xmodem_packet_receiver_top.sv
test/xmodem_packet_receiver_checker.sv
test/tb_xmodem_packet_receiver_top.sv
